// ===== design/igmp_pkg.sv =====
// Package for the IGMPv2 router group membership block.
// Holds payload structs, code and state enums and a shared helper; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package igmp_pkg;
    localparam int GROUPS = 16;
    localparam int IDX_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int CNT_W = $clog2(GROUPS + 1);

    typedef enum logic [1:0] {KIND_TICK, KIND_REPORT, KIND_LEAVE, KIND_QUERY} kind_t;
    typedef enum logic [1:0] {ACT_GENQ, ACT_GRPQ, ACT_ADD, ACT_REMOVE} act_t;
    typedef enum logic [1:0] {ROLE_INITIAL, ROLE_QUERIER, ROLE_NON_QUERIER, ROLE_UNUSED} role_t;
    typedef enum logic [1:0] {ST_NONE, ST_PRESENT, ST_CHECKING, ST_UNUSED} est_t;
    typedef enum logic [2:0] {
        CFG_OWN, CFG_QP, CFG_QRT, CFG_MT, CFG_OQT, CFG_SQP, CFG_LMP, CFG_LMC
    } cfg_idx_t;
    typedef enum logic [2:0] {S_IDLE, S_HEAD, S_SCAN, S_APPLY, S_EMIT, S_WAIT} seq_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] group_addr;
        logic [31:0] sender_addr;
        logic [15:0] resp_time;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] out_group;
        logic [15:0] out_resp_time;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [15:0] query_period;
        logic [15:0] query_response_time;
        logic [15:0] membership_timeout;
        logic [15:0] other_querier_timeout;
        logic [15:0] startup_query_period;
        logic [15:0] last_member_period;
        logic [3:0]  last_member_count;
    } cfg_t;

    function automatic logic [15:0] at_least_one(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction
endpackage
`default_nettype wire

// ===== design/igmp_mul.sv =====
// Shared shift-add multiplier: 16 x 4 bits, one multiplier bit per cycle.
// Depends on igmp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module igmp_mul (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [15:0] a,
    input  wire logic [3:0]  b,
    output logic             done,
    output logic [19:0]      product
);
    import igmp_pkg::*;
    logic [19:0] acc_reg, acc_next, a_reg, a_next;
    logic [3:0]  b_reg, b_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;

    always_comb
    begin
        acc_next = acc_reg; a_next = a_reg; b_next = b_reg;
        cnt_next = cnt_reg; busy_next = busy_reg;
        if (start)
        begin
            acc_next = 20'd0; a_next = {4'd0, a}; b_next = b;
            cnt_next = 3'd4; busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (b_reg[0]) acc_next = acc_reg + a_reg;
            a_next = a_reg << 1; b_next = b_reg >> 1;
            cnt_next = cnt_reg - 3'd1;
            if (cnt_reg == 3'd1) busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0; cnt_reg <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next; cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next; a_reg <= a_next; b_reg <= b_next;
    end

    assign done = busy_reg && (cnt_reg == 3'd1);
    assign product = acc_next;
endmodule
`default_nettype wire

// ===== design/igmp_router_group_membership.sv =====
// Top level of the IGMPv2 router group membership block.
// Uses igmp_pkg and igmp_mul.
//
// Usage: items enter on in_valid/in_ready/in_data (ticks, reports, leaves,
// queries); results leave on out_valid/out_ready/out_data, the final result
// of an item carries last. Configuration is written with cfg_we/cfg_index/
// cfg_data while idle. One item at a time: the sequencer walks the group
// table once per item with one shared compare/decrement unit, one entry a
// cycle unless an output stall holds the scan. An item passes through a
// head state, a scan over every entry, an apply state and an emit state
// before the block is idle again, plus a wait on the serial multiply for a
// leave or group-specific query that sets a leave time, plus any stall by
// the receiver. Results found during the scan leave while the scan goes on.
// in_ready is low while an item is being worked on. A stall on the output
// holds the scan where it is; nothing is dropped. Reset returns the role to
// initial, stops the query timer and clears all valid bits; no clearing pass
// is needed.
`timescale 1ns / 1ps
`default_nettype none
module igmp_router_group_membership (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire igmp_pkg::in_item_t in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output igmp_pkg::out_item_t     out_data,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);
    import igmp_pkg::*;

    logic [31:0] own_reg;
    cfg_t        cfg_reg;
    role_t       role_reg, role_next;
    logic [15:0] qcd_reg, qcd_next;
    logic [GROUPS-1:0] val_reg, val_next;
    logic [31:0] grp_mem [GROUPS];
    est_t        st_reg  [GROUPS];
    logic [19:0] lcd_reg [GROUPS];
    logic [15:0] rcd_reg [GROUPS];

    seq_t        seq_reg, seq_next;
    in_item_t    item_reg;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic        hit_reg, hit_next, free_found_reg, free_found_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next, free_idx_reg, free_idx_next;
    out_item_t   pend_reg, pend_next;
    logic        pend_v_reg, pend_v_next;
    out_item_t   obuf_reg;
    logic        obuf_v_reg;

    // entry write port
    logic        ew;
    logic [IDX_W-1:0] ew_idx;
    logic        ew_valid, ew_grp_we;
    est_t        ew_st;
    logic [19:0] ew_lcd;
    logic [15:0] ew_rcd;

    logic        mul_start, mul_done;
    logic [15:0] mul_a;
    logic [19:0] mul_p;
    logic        scan_last, emit_now, obuf_free, emit_last;
    logic [15:0] lmp1;
    logic [3:0]  lmc1;
    out_item_t   scan_res;
    logic        scan_res_v;

    assign lmc1 = (cfg_reg.last_member_count == 4'd0) ? 4'd1 : cfg_reg.last_member_count;

    igmp_mul u_mul (
        .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a),
        .b(lmc1), .done(mul_done), .product(mul_p)
    );

    assign lmp1      = at_least_one(cfg_reg.last_member_period);
    assign scan_last = (idx_reg == IDX_W'(GROUPS - 1));
    assign obuf_free = !obuf_v_reg || out_ready;
    assign in_ready  = (seq_reg == S_IDLE);
    assign out_valid = obuf_v_reg;
    assign out_data  = obuf_reg;
    assign mul_a     = (item_reg.kind == KIND_LEAVE) ? lmp1 : at_least_one(item_reg.resp_time);
    assign mul_start = (seq_reg == S_APPLY) && (
        (item_reg.kind == KIND_LEAVE && hit_reg && st_reg[hit_idx_reg] == ST_PRESENT
            && role_reg == ROLE_QUERIER)
        || (item_reg.kind == KIND_QUERY && item_reg.group_addr != 32'd0 && hit_reg
            && st_reg[hit_idx_reg] == ST_PRESENT && role_reg == ROLE_NON_QUERIER));

    always_comb
    begin
        seq_next = seq_reg; idx_next = idx_reg;
        hit_next = hit_reg; hit_idx_next = hit_idx_reg;
        free_found_next = free_found_reg; free_idx_next = free_idx_reg;
        role_next = role_reg; qcd_next = qcd_reg; val_next = val_reg;
        pend_next = pend_reg; pend_v_next = pend_v_reg; emit_now = 1'b0;
        ew = 1'b0; ew_idx = idx_reg; ew_valid = 1'b0; ew_grp_we = 1'b0;
        ew_st = ST_NONE; ew_lcd = 20'd0; ew_rcd = 16'd0;
        scan_res = '0; scan_res_v = 1'b0;
        case (seq_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    seq_next = S_HEAD; idx_next = '0; hit_next = 1'b0;
                    free_found_next = 1'b0; pend_v_next = 1'b0;
                end
            end
            S_HEAD:
            begin
                if (item_reg.kind == KIND_TICK)
                begin
                    if (role_reg == ROLE_INITIAL)
                    begin
                        role_next = ROLE_QUERIER;
                        qcd_next = at_least_one(cfg_reg.startup_query_period);
                        pend_next = '{ACT_GENQ, 32'd0, cfg_reg.query_response_time, 1'b0};
                        pend_v_next = 1'b1;
                    end
                    else if (qcd_reg != 16'd0)
                    begin
                        qcd_next = qcd_reg - 16'd1;
                        if (qcd_reg == 16'd1)
                        begin
                            role_next = ROLE_QUERIER;
                            qcd_next = at_least_one(cfg_reg.query_period);
                            pend_next = '{ACT_GENQ, 32'd0, cfg_reg.query_response_time, 1'b0};
                            pend_v_next = 1'b1;
                        end
                    end
                end
                else if (item_reg.kind == KIND_QUERY && item_reg.sender_addr < own_reg)
                begin
                    role_next = ROLE_NON_QUERIER;
                    qcd_next = at_least_one(cfg_reg.other_querier_timeout);
                end
                seq_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (item_reg.kind == KIND_TICK)
                begin
                    if (val_reg[idx_reg])
                    begin
                        ew = 1'b1; ew_valid = 1'b1; ew_st = st_reg[idx_reg];
                        ew_lcd = lcd_reg[idx_reg]; ew_rcd = rcd_reg[idx_reg];
                        if (lcd_reg[idx_reg] == 20'd1)
                        begin
                            ew_valid = 1'b0; ew_st = ST_NONE;
                            ew_lcd = 20'd0; ew_rcd = 16'd0;
                            scan_res = '{ACT_REMOVE, grp_mem[idx_reg], 16'd0, 1'b0};
                            scan_res_v = 1'b1;
                        end
                        else
                        begin
                            if (lcd_reg[idx_reg] != 20'd0)
                                ew_lcd = lcd_reg[idx_reg] - 20'd1;
                            if (rcd_reg[idx_reg] == 16'd1)
                            begin
                                ew_rcd = lmp1; ew_st = ST_CHECKING;
                                if (role_reg == ROLE_QUERIER)
                                begin
                                    scan_res = '{ACT_GRPQ, grp_mem[idx_reg], lmp1, 1'b0};
                                    scan_res_v = 1'b1;
                                end
                            end
                            else if (rcd_reg[idx_reg] != 16'd0)
                                ew_rcd = rcd_reg[idx_reg] - 16'd1;
                        end
                        val_next[idx_reg] = ew_valid;
                    end
                end
                else
                begin
                    if (val_reg[idx_reg] && grp_mem[idx_reg] == item_reg.group_addr
                        && !hit_reg)
                    begin
                        hit_next = 1'b1; hit_idx_next = idx_reg;
                    end
                    if (!val_reg[idx_reg] && !free_found_reg)
                    begin
                        free_found_next = 1'b1; free_idx_next = idx_reg;
                    end
                end
                if (scan_res_v && pend_v_reg && !obuf_free)
                begin
                    ew = 1'b0; val_next = val_reg;
                end
                else
                begin
                    if (scan_res_v)
                    begin
                        emit_now = pend_v_reg; pend_next = scan_res; pend_v_next = 1'b1;
                    end
                    if (scan_last)
                        seq_next = S_APPLY;
                    else
                        idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_APPLY:
            begin
                seq_next = S_EMIT;
                if (item_reg.kind == KIND_REPORT)
                begin
                    ew_lcd = 20'(at_least_one(cfg_reg.membership_timeout));
                    ew_st = ST_PRESENT; ew_valid = 1'b1;
                    if (hit_reg)
                    begin
                        ew = 1'b1; ew_idx = hit_idx_reg;
                        ew_rcd = (st_reg[hit_idx_reg] == ST_CHECKING) ? 16'd0
                                 : rcd_reg[hit_idx_reg];
                        if (st_reg[hit_idx_reg] == ST_NONE)
                        begin
                            pend_next = '{ACT_ADD, item_reg.group_addr, 16'd0, 1'b0};
                            pend_v_next = 1'b1;
                        end
                    end
                    else if (free_found_reg)
                    begin
                        ew = 1'b1; ew_idx = free_idx_reg; ew_grp_we = 1'b1;
                        val_next[free_idx_reg] = 1'b1;
                        pend_next = '{ACT_ADD, item_reg.group_addr, 16'd0, 1'b0};
                        pend_v_next = 1'b1;
                    end
                end
                else if (mul_start)
                    seq_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (mul_done)
                begin
                    ew = 1'b1; ew_idx = hit_idx_reg; ew_valid = 1'b1;
                    ew_st = ST_CHECKING; ew_lcd = mul_p;
                    if (item_reg.kind == KIND_LEAVE)
                    begin
                        ew_rcd = lmp1;
                        pend_next = '{ACT_GRPQ, item_reg.group_addr, lmp1, 1'b0};
                        pend_v_next = 1'b1;
                    end
                    else
                        ew_rcd = rcd_reg[hit_idx_reg];
                    seq_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!pend_v_reg)
                    seq_next = S_IDLE;
                else if (obuf_free)
                begin
                    emit_now = 1'b1; pend_v_next = 1'b0; seq_next = S_IDLE;
                end
            end
            default: seq_next = S_IDLE;
        endcase
    end

    // mark last on the result held back until S_EMIT
    assign emit_last = (seq_reg == S_EMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg <= S_IDLE; role_reg <= ROLE_INITIAL; qcd_reg <= 16'd0;
            val_reg <= '0; pend_v_reg <= 1'b0; obuf_v_reg <= 1'b0;
            own_reg <= 32'd0;
            cfg_reg <= '{16'd125, 16'd10, 16'd260, 16'd255, 16'd31, 16'd1, 4'd2};
            for (int i = 0; i < GROUPS; i++)
            begin
                st_reg[i] <= ST_NONE; lcd_reg[i] <= 20'd0; rcd_reg[i] <= 16'd0;
            end
        end
        else
        begin
            seq_reg <= seq_next; role_reg <= role_next; qcd_reg <= qcd_next;
            val_reg <= val_next; pend_v_reg <= pend_v_next;
            if (emit_now)
                obuf_v_reg <= 1'b1;
            else if (out_ready)
                obuf_v_reg <= 1'b0;
            if (ew)
            begin
                st_reg[ew_idx] <= ew_st; lcd_reg[ew_idx] <= ew_lcd;
                rcd_reg[ew_idx] <= ew_rcd;
            end
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_OWN: own_reg <= cfg_data;
                    CFG_QP:  cfg_reg.query_period <= cfg_data[15:0];
                    CFG_QRT: cfg_reg.query_response_time <= cfg_data[15:0];
                    CFG_MT:  cfg_reg.membership_timeout <= cfg_data[15:0];
                    CFG_OQT: cfg_reg.other_querier_timeout <= cfg_data[15:0];
                    CFG_SQP: cfg_reg.startup_query_period <= cfg_data[15:0];
                    CFG_LMP: cfg_reg.last_member_period <= cfg_data[15:0];
                    CFG_LMC: cfg_reg.last_member_count <= cfg_data[3:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_reg == S_IDLE && in_valid)
            item_reg <= in_data;
        idx_reg <= idx_next; hit_reg <= hit_next; hit_idx_reg <= hit_idx_next;
        free_found_reg <= free_found_next; free_idx_reg <= free_idx_next;
        pend_reg <= pend_next;
        if (ew_grp_we)
            grp_mem[ew_idx] <= item_reg.group_addr;
        if (emit_now)
        begin
            obuf_reg <= pend_reg;
            obuf_reg.last <= emit_last;
        end
    end

    property p_busy_no_ready;
        @(posedge clk) disable iff (!rst_n) (seq_reg != S_IDLE) |-> !in_ready;
    endproperty
    a_busy: assert property (p_busy_no_ready) else $error("ready while busy");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(out_data))
        else $error("output dropped under stall");
    a_role: assert property (@(posedge clk) disable iff (!rst_n)
        role_reg != ROLE_UNUSED) else $error("unused role");
    a_emit: assert property (@(posedge clk) disable iff (!rst_n)
        emit_now |-> pend_v_reg) else $error("emit without pending result");
endmodule
`default_nettype wire
